### hw/rtl/climate_bus_frame_receiver_assert.svh
// assertion macros shared by the climate bus frame receiver checkers
// depends on nothing; included by files that hold concurrent assertions
`ifndef CLIMATE_BUS_FRAME_RECEIVER_ASSERT_SVH
`define CLIMATE_BUS_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define CBFR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define CBFR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/cbfr_pkg.sv
// types and constants of the climate bus frame receiver
// depends on nothing; imported by every module of the block
package cbfr_pkg;

    localparam int unsigned ADDR_W = 4;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_START_MARKER    = 2'd0;
    localparam logic [1:0] REG_UNIT_END_MARKER = 2'd1;
    localparam logic [1:0] REG_UNIT_ALT_MARKER = 2'd2;
    localparam logic [1:0] REG_CTRL_END_MARKER = 2'd3;

    localparam logic [7:0] START_MARKER_RST    = 8'd254;
    localparam logic [7:0] UNIT_END_MARKER_RST = 8'd107;
    localparam logic [7:0] UNIT_ALT_MARKER_RST = 8'd235;
    localparam logic [7:0] CTRL_END_MARKER_RST = 8'd75;

    // decode window layout
    localparam logic [2:0] WIN_LAST  = 3'd7;
    localparam logic [2:0] WIN_POS_A = 3'd3;
    localparam logic [2:0] WIN_POS_S = 3'd4;
    localparam logic [2:0] WIN_POS_R = 3'd6;
    localparam logic [7:0] BYTE_INV  = 8'hFF;

    localparam logic [2:0] MODE_MIN = 3'd1;
    localparam logic [2:0] MODE_MAX = 3'd5;
    localparam logic [2:0] FAN_MAX  = 3'd4;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_UNIT = 2'd1,
        EV_CTRL = 2'd2,
        EV_DROP = 2'd3
    } frame_ev_t;

    typedef enum logic [1:0] {
        PH_SEEK    = 2'd0,
        PH_SKIP    = 2'd1,
        PH_CAPTURE = 2'd2
    } win_phase_t;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] unit_end_marker;
        logic [7:0] unit_end_alt_marker;
        logic [7:0] ctrl_end_marker;
    } cfg_t;

    typedef struct packed {
        logic       power_on;
        logic [2:0] op_mode;
        logic [2:0] fan_speed;
        logic       error_flag;
        logic       economy_on;
        logic [6:0] setpoint_deg;
        logic [6:0] room_deg;
        logic       sensor_bit;
    } status_t;

endpackage

### hw/rtl/cbfr_regs.sv
// configuration registers behind the apb-style port
// depends on cbfr_pkg for the register indexes and the cfg_t struct
module cbfr_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cbfr_pkg::ADDR_W-1:0]         paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output cbfr_pkg::cfg_t                      cfg
);
    import cbfr_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_START_MARKER:    cfg_next.start_marker        = pwdata[7:0];
                REG_UNIT_END_MARKER: cfg_next.unit_end_marker     = pwdata[7:0];
                REG_UNIT_ALT_MARKER: cfg_next.unit_end_alt_marker = pwdata[7:0];
                REG_CTRL_END_MARKER: cfg_next.ctrl_end_marker     = pwdata[7:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_marker        <= START_MARKER_RST;
            cfg_reg.unit_end_marker     <= UNIT_END_MARKER_RST;
            cfg_reg.unit_end_alt_marker <= UNIT_ALT_MARKER_RST;
            cfg_reg.ctrl_end_marker     <= CTRL_END_MARKER_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_START_MARKER:    prdata = {24'd0, cfg_reg.start_marker};
            REG_UNIT_END_MARKER: prdata = {24'd0, cfg_reg.unit_end_marker};
            REG_UNIT_ALT_MARKER: prdata = {24'd0, cfg_reg.unit_end_alt_marker};
            REG_CTRL_END_MARKER: prdata = {24'd0, cfg_reg.ctrl_end_marker};
            default:             prdata = 32'd0;
        endcase
    end

endmodule

### hw/rtl/cbfr_frame_framer.sv
// frame framer: locks on the start marker, counts fixed-length frames and
// classifies each one; depends on cbfr_pkg for cfg_t and the event codes
module cbfr_frame_framer #(
    parameter int unsigned FRAME_BYTES = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic [7:0]            rx_byte,
    input  cbfr_pkg::cfg_t        cfg,
    output cbfr_pkg::frame_ev_t   frame_event
);
    import cbfr_pkg::*;

    localparam int unsigned CNT_W = $clog2(FRAME_BYTES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_BYTES - 1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [CNT_W-1:0] raw_count_reg, raw_count_next;
    logic [7:0]       raw_first_reg, raw_first_next;
    logic             expect_ctrl_reg, expect_ctrl_next;
    frame_ev_t        event_reg, event_next;
    logic             is_start;
    logic             unit_ok;
    logic             ctrl_ok;

    assign is_start = (raw_first_reg == cfg.start_marker);
    assign unit_ok  = is_start && (rx_byte == cfg.unit_end_marker ||
                                   rx_byte == cfg.unit_end_alt_marker);
    assign ctrl_ok  = !is_start && (rx_byte == cfg.ctrl_end_marker);

    always_comb begin
        raw_count_next   = raw_count_reg;
        raw_first_next   = raw_first_reg;
        expect_ctrl_next = expect_ctrl_reg;
        event_next       = EV_NONE;
        if (raw_count_reg == '0) begin
            // idle: only the marker, or any byte while a control frame is due
            if (rx_byte == cfg.start_marker || expect_ctrl_reg) begin
                raw_first_next = rx_byte;
                raw_count_next = CNT_ONE;
            end
        end else if (raw_count_reg == CNT_LAST) begin
            raw_count_next = '0;
            if (unit_ok) begin
                expect_ctrl_next = 1'b1;
                event_next       = EV_UNIT;
            end else if (ctrl_ok) begin
                expect_ctrl_next = 1'b0;
                event_next       = EV_CTRL;
            end else begin
                expect_ctrl_next = 1'b0;
                event_next       = EV_DROP;
            end
        end else begin
            raw_count_next = raw_count_reg + CNT_ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_count_reg   <= '0;
            raw_first_reg   <= '0;
            expect_ctrl_reg <= 1'b0;
            event_reg       <= EV_NONE;
        end else if (accept) begin
            raw_count_reg   <= raw_count_next;
            raw_first_reg   <= raw_first_next;
            expect_ctrl_reg <= expect_ctrl_next;
            event_reg       <= event_next;
        end
    end

    assign frame_event = event_reg;

endmodule

### hw/rtl/cbfr_window_decoder.sv
// decode framer: skips one byte after the marker, inverts an eight-byte
// window and decodes the held status; depends on cbfr_pkg
module cbfr_window_decoder (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic [7:0]            rx_byte,
    input  cbfr_pkg::cfg_t        cfg,
    output logic                  status_update,
    output cbfr_pkg::status_t     status
);
    import cbfr_pkg::*;

    win_phase_t phase_reg, phase_next;
    logic [2:0] win_count_reg, win_count_next;
    logic [7:0] win_a_reg, win_s_reg, win_r_reg;
    status_t    status_reg, status_next;
    logic       update_reg;
    logic       store_a, store_s, store_r;
    logic       decode;
    logic [7:0] inv_byte;
    logic [2:0] dec_mode;
    logic [2:0] dec_fan;

    assign inv_byte = rx_byte ^ BYTE_INV;

    // next phase
    always_comb begin
        unique case (phase_reg)
            PH_SEEK:    phase_next = (rx_byte == cfg.start_marker) ? PH_SKIP : PH_SEEK;
            PH_SKIP:    phase_next = PH_CAPTURE;
            PH_CAPTURE: phase_next = (win_count_reg == WIN_LAST) ? PH_SEEK : PH_CAPTURE;
            default:    phase_next = (rx_byte == cfg.start_marker) ? PH_SKIP : PH_SEEK;
        endcase
    end

    // phase outputs
    always_comb begin
        store_a        = 1'b0;
        store_s        = 1'b0;
        store_r        = 1'b0;
        decode         = 1'b0;
        win_count_next = win_count_reg;
        unique case (phase_reg)
            PH_SKIP: begin
                win_count_next = '0;
            end
            PH_CAPTURE: begin
                store_a = (win_count_reg == WIN_POS_A);
                store_s = (win_count_reg == WIN_POS_S);
                store_r = (win_count_reg == WIN_POS_R);
                decode  = (win_count_reg == WIN_LAST);
                win_count_next = decode ? 3'd0 : win_count_reg + 3'd1;
            end
            default: begin
                win_count_next = win_count_reg;
            end
        endcase
    end

    assign dec_mode = win_a_reg[3:1];
    assign dec_fan  = win_a_reg[6:4];

    always_comb begin
        status_next = status_reg;
        if (decode) begin
            status_next.power_on     = win_a_reg[0];
            status_next.error_flag   = win_a_reg[7];
            status_next.economy_on   = win_s_reg[7];
            status_next.setpoint_deg = win_s_reg[6:0];
            status_next.sensor_bit   = win_r_reg[0];
            status_next.room_deg     = win_r_reg[7:1];
            // mode and fan only move on codes that mean something
            if (dec_mode >= MODE_MIN && dec_mode <= MODE_MAX) begin
                status_next.op_mode = dec_mode;
            end
            if (dec_fan <= FAN_MAX) begin
                status_next.fan_speed = dec_fan;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SEEK;
            win_count_reg <= '0;
            status_reg    <= '0;
            update_reg    <= 1'b0;
        end else if (accept) begin
            phase_reg     <= phase_next;
            win_count_reg <= win_count_next;
            status_reg    <= status_next;
            update_reg    <= decode;
        end
    end

    // window bytes are always written before the decode reads them
    always_ff @(posedge aclk) begin
        if (accept && store_a) begin
            win_a_reg <= inv_byte;
        end
        if (accept && store_s) begin
            win_s_reg <= inv_byte;
        end
        if (accept && store_r) begin
            win_r_reg <= inv_byte;
        end
    end

    assign status_update = update_reg;
    assign status        = status_reg;

endmodule

### hw/rtl/climate_bus_frame_receiver.sv
// top level of the climate bus frame receiver
// depends on cbfr_pkg, cbfr_regs, cbfr_frame_framer and cbfr_window_decoder

// Takes one received bus byte per transfer and returns exactly one result per
// byte in the cycle after it is taken; one byte per clock with m_ready high.
// The framers' state registers double as the result register, so s_ready stays
// high while a result waits only if m_ready takes it in the same cycle; with
// m_ready held high the block never stalls. The frame framer reports a unit,
// control or dropped frame on the last byte of every FRAME_BYTES-byte frame;
// the decode framer raises m_status_update on the last byte of its window and
// the status fields hold their values between windows (0 after reset). Marker
// registers sit at byte addresses 0, 4, 8 and 12 and must be written while idle.
module climate_bus_frame_receiver #(
    parameter int unsigned FRAME_BYTES = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cbfr_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // byte input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_rx_byte,
    // result output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_frame_event,
    output logic                          m_status_update,
    output logic                          m_power_on,
    output logic [2:0]                    m_op_mode,
    output logic [2:0]                    m_fan_speed,
    output logic                          m_error_flag,
    output logic                          m_economy_on,
    output logic [6:0]                    m_setpoint_deg,
    output logic [6:0]                    m_room_deg,
    output logic                          m_sensor_bit
);
    import cbfr_pkg::*;

    cfg_t      cfg;
    status_t   status;
    frame_ev_t frame_event;
    logic      accept;
    logic      m_valid_reg, m_valid_next;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    cbfr_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cbfr_frame_framer #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_frame_framer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .rx_byte     (s_rx_byte),
        .cfg         (cfg),
        .frame_event (frame_event)
    );

    cbfr_window_decoder u_window_decoder (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .rx_byte       (s_rx_byte),
        .cfg           (cfg),
        .status_update (m_status_update),
        .status        (status)
    );

    assign m_valid        = m_valid_reg;
    assign m_frame_event  = frame_event;
    assign m_power_on     = status.power_on;
    assign m_op_mode      = status.op_mode;
    assign m_fan_speed    = status.fan_speed;
    assign m_error_flag   = status.error_flag;
    assign m_economy_on   = status.economy_on;
    assign m_setpoint_deg = status.setpoint_deg;
    assign m_room_deg     = status.room_deg;
    assign m_sensor_bit   = status.sensor_bit;

endmodule

### hw/rtl/cbfr_checker.sv
// port-level checker for the climate bus frame receiver, bound to the top level
// depends on cbfr_pkg and climate_bus_frame_receiver_assert.svh
`include "climate_bus_frame_receiver_assert.svh"

module cbfr_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [1:0]                    m_frame_event,
    input  logic                          m_status_update,
    input  logic                          m_power_on,
    input  logic [2:0]                    m_op_mode,
    input  logic [2:0]                    m_fan_speed,
    input  logic                          m_error_flag,
    input  logic                          m_economy_on,
    input  logic [6:0]                    m_setpoint_deg,
    input  logic [6:0]                    m_room_deg,
    input  logic                          m_sensor_bit
);
    import cbfr_pkg::*;

    logic [26:0] out_payload;
    logic [26:0] payload_q;
    logic        stall_q;
    logic        payload_held;
    logic        in_xfer;
    logic        range_ok;

    assign out_payload = {m_frame_event, m_status_update, m_power_on, m_op_mode,
                          m_fan_speed, m_error_flag, m_economy_on, m_setpoint_deg,
                          m_room_deg, m_sensor_bit};

    // previous cycle's stall and payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stall_q   <= 1'b0;
            payload_q <= '0;
        end else begin
            stall_q   <= m_valid && !m_ready;
            payload_q <= out_payload;
        end
    end

    assign payload_held = m_valid && (out_payload == payload_q);
    assign in_xfer      = s_valid && s_ready;
    assign range_ok     = (m_op_mode <= MODE_MAX) && (m_fan_speed <= FAN_MAX);

    // a stalled result keeps its payload
    `CBFR_ASSERT_NOW(a_out_hold, aclk, aresetn, stall_q, payload_held, "stalled result changed")

    // every accepted byte shows a result in the next cycle
    `CBFR_ASSERT_NEXT(a_in_to_out, aclk, aresetn, in_xfer, m_valid, "byte taken, no result")

    // with no result pending the input side is open
    `CBFR_ASSERT_NOW(a_ready_empty, aclk, aresetn, !m_valid, s_ready, "empty but not ready")

    // held mode and fan never take a code above their maximum
    `CBFR_ASSERT_NOW(a_held_range, aclk, aresetn, m_valid, range_ok, "mode or fan out of range")

endmodule

bind climate_bus_frame_receiver cbfr_checker u_checker (.*);
